// ===== rtl/servo_motion_interpolator_assert.svh =====
// assertion macros for the servo motion interpolator
`ifndef SERVO_MOTION_INTERPOLATOR_ASSERT_SVH
`define SERVO_MOTION_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTH
`define SMI_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SMI_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SMI_ASSERT_IMP(label, clk, rst, a, c)
`define SMI_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/smi_pkg.sv =====
// package: shared types and constants for the servo motion interpolator
`default_nettype none
package smi_pkg;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned DUR_W = 10;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  // numerator of the interpolation division: TICK_MS*k stays below duration_ms,
  // so TICK_MS*k*diff fits in duration bits plus angle bits
  localparam int unsigned NUM_W = DUR_W + ANGLE_W;
  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [DUR_W-1:0] dur_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef struct packed {
    logic start;
    logic down;
    num_t num;
    dur_t dur;
    logic [ANGLE_W-1:0] diff;
    angle_t base;
  } lane_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/smi_if.sv =====
// valid/ready channel interface
`default_nettype none
interface smi_if #(parameter int unsigned W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/smi_lane.sv =====
// one joint lane: serial restoring divider and angle step
`default_nettype none
module smi_lane (
  input  wire logic clk,
  input  wire logic rst,
  input  wire smi_pkg::lane_cmd_t cmd,
  output logic done,
  output smi_pkg::angle_t angle
);
  import smi_pkg::*;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  logic busy;
  logic [CNT_W-1:0] cnt;
  num_t quo;
  logic [DUR_W-1:0] rem;
  logic [DUR_W:0] trial;
  logic [NUM_W-1:0] step_sat;
  assign trial = {rem, quo[NUM_W-1]} - {1'b0, cmd.dur};
  assign step_sat = (quo > num_t'(cmd.diff)) ? num_t'(cmd.diff) : quo;
  assign angle = cmd.down ? angle_t'(cmd.base - step_sat[ANGLE_W-1:0])
                          : angle_t'(cmd.base + step_sat[ANGLE_W-1:0]);
  assign done = ~busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(NUM_W);
      quo <= cmd.num;
      rem <= '0;
    end else if (busy) begin
      // one quotient bit a cycle
      if (!trial[DUR_W]) begin
        rem <= trial[DUR_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DUR_W-2:0], quo[NUM_W-1]};
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/servo_motion_interpolator.sv =====
// top level: command sequencer, joint lanes and output merge
// channel | dir | payload
// cmd     | in  | eight target angles, duration_ms
// servo   | out | eight servo angles, last_tick
// each tick runs lane load, the lanes' serial dividers, merge and output beat, in that order
// a command is accepted, then runs duration_ms/TICK_MS ticks (at most MAX_TICKS)
// reset clears joint angles and the sequencer; the next command waits for the last beat
// a stalled output holds the sequencer; ticks advance only once a beat is taken
`default_nettype none
module servo_motion_interpolator #(
  parameter int unsigned NUM_JOINTS = 8,
  parameter int unsigned TICK_MS = 10,
  parameter int unsigned MAX_TICKS = 64
) (
  input wire logic clk,
  input wire logic rst,
  smi_if.sink cmd,
  smi_if.source servo
);
  import smi_pkg::*;
  `include "servo_motion_interpolator_assert.svh"
  localparam int unsigned TK_W = $clog2(MAX_TICKS + 1);
  // tick count by reciprocal multiplication, exact for every duration
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned RECIP_W = RECIP_SH + 1;
  localparam logic [RECIP_SH:0] TICK_RECIP =
    RECIP_W'(((32'd1 << RECIP_SH) + TICK_MS - 1) / TICK_MS);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;
  logic [1:0] state;
  angle_t joint [NUM_JOINTS];
  angle_t start_a [NUM_JOINTS];
  angle_t target [NUM_JOINTS];
  dur_t dur;
  logic [TK_W-1:0] ticks, k;
  logic [NUM_JOINTS-1:0] lane_done;
  angle_t lane_angle [NUM_JOINTS];
  lane_cmd_t lane_cmd [NUM_JOINTS];
  dur_t in_dur;
  logic [DUR_W+RECIP_SH:0] in_prod;
  logic [DUR_W-1:0] in_ticks;
  assign in_dur = cmd.data[NUM_JOINTS*ANGLE_W +: DUR_W];
  assign in_prod = {{RECIP_W{1'b0}}, in_dur} * {{DUR_W{1'b0}}, TICK_RECIP};
  assign in_ticks = in_prod[RECIP_SH +: DUR_W];
  assign cmd.ready = (state == S_IDLE);
  assign servo.valid = (state == S_OUT);
  genvar g;
  generate
    for (g = 0; g < NUM_JOINTS; g++) begin : g_lane
      logic [ANGLE_W-1:0] diff;
      assign diff = (start_a[g] > target[g]) ? start_a[g] - target[g]
                                             : target[g] - start_a[g];
      assign lane_cmd[g].start = (state == S_RUN);
      assign lane_cmd[g].down = start_a[g] > target[g];
      assign lane_cmd[g].num = num_t'(TICK_MS * k * diff);
      assign lane_cmd[g].dur = dur;
      assign lane_cmd[g].diff = diff;
      assign lane_cmd[g].base = start_a[g];
      smi_lane u_lane (.clk(clk), .rst(rst), .cmd(lane_cmd[g]),
                       .done(lane_done[g]), .angle(lane_angle[g]));
      if (g >= NUM_JOINTS / 2) begin : g_mir
        assign servo.data[g*ANGLE_W +: ANGLE_W] = ANGLE_MAX - joint[g];
      end else begin : g_dir
        assign servo.data[g*ANGLE_W +: ANGLE_W] = joint[g];
      end
    end
  endgenerate
  assign servo.data[NUM_JOINTS*ANGLE_W] = (k + 1'b1 == ticks);
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= '0;
      for (int j = 0; j < NUM_JOINTS; j++) joint[j] <= '0;
    end else begin
      case (state)
        S_IDLE: if (cmd.valid && in_ticks != '0) begin
          for (int j = 0; j < NUM_JOINTS; j++) begin
            start_a[j] <= joint[j];
            target[j] <= (cmd.data[j*ANGLE_W +: ANGLE_W] > ANGLE_MAX) ? ANGLE_MAX
                         : cmd.data[j*ANGLE_W +: ANGLE_W];
          end
          dur <= in_dur;
          ticks <= (in_ticks > DUR_W'(MAX_TICKS)) ? TK_W'(MAX_TICKS)
                                                 : in_ticks[TK_W-1:0];
          k <= '0;
          state <= S_RUN;
        end
        S_RUN: state <= S_WAIT;
        S_WAIT: if (&lane_done) begin
          // merge: commit all lanes at once
          for (int j = 0; j < NUM_JOINTS; j++) joint[j] <= lane_angle[j];
          state <= S_OUT;
        end
        S_OUT: if (servo.ready) begin
          if (k + 1'b1 == ticks) begin
            k <= '0;
            state <= S_IDLE;
          end else begin
            k <= k + 1'b1;
            state <= S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  `SMI_ASSERT_IMP(a_no_in_busy, clk, rst, state != S_IDLE, !cmd.ready)
  `SMI_ASSERT_NEXT(a_run_wait, clk, rst, state == S_RUN, state == S_WAIT)
  `SMI_ASSERT_IMP(a_k_range, clk, rst, state != S_IDLE, k < ticks)
  `SMI_ASSERT_NEXT(a_hold, clk, rst, servo.valid && !servo.ready, servo.valid)
endmodule
`default_nettype wire

// ===== test/tb_servo_motion_interpolator.sv =====
// testbench for the servo motion interpolator: predicts each tick and checks every servo beat
`timescale 1ns / 100ps
`default_nettype none
module tb_servo_motion_interpolator;
  import smi_pkg::*;

  localparam int unsigned JOINTS = 8;
  localparam int unsigned TICK = 10;
  localparam int unsigned TICKS_MAX = 64;
  localparam int unsigned CMD_W = JOINTS * ANGLE_W + DUR_W;
  localparam int unsigned SERVO_W = JOINTS * ANGLE_W + 1;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    dur_t dur;
    angle_t [JOINTS-1:0] target;  // element 0 is lf_upper, element 7 is rb_lower
  } motion_cmd_t;

  typedef struct packed {
    logic last;
    angle_t [JOINTS-1:0] angle;   // element 0 is lf_upper, element 7 is rb_lower
  } servo_beat_t;

  logic clk;
  logic rst;
  smi_if #(.W(CMD_W)) cmd ();
  smi_if #(.W(SERVO_W)) servo ();

  servo_motion_interpolator dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd.sink),
    .servo(servo.source)
  );

  angle_t joint_pos[JOINTS];
  servo_beat_t servo_expected[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  longint unsigned cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one joint moved k ticks of the way from its latched start
  function automatic angle_t glide(angle_t from, angle_t dst, int unsigned k, dur_t dur);
    int unsigned diff;
    int unsigned step;
    if (dur == 0 || from == dst) return from;
    diff = (from > dst) ? from - dst : dst - from;
    step = (TICK * k * diff) / dur;
    if (step > diff) step = diff;
    return (from > dst) ? angle_t'(from - step) : angle_t'(from + step);
  endfunction

  task automatic predict_motion(motion_cmd_t c);
    int unsigned ticks;
    angle_t start[JOINTS];
    angle_t dst[JOINTS];
    angle_t a;
    servo_beat_t b;
    ticks = c.dur / TICK;
    if (ticks == 0) return;
    if (ticks > TICKS_MAX) ticks = TICKS_MAX;
    for (int j = 0; j < JOINTS; j++) begin
      dst[j] = (c.target[j] > ANGLE_MAX) ? ANGLE_MAX : c.target[j];
      start[j] = joint_pos[j];
    end
    for (int unsigned k = 0; k < ticks; k++) begin
      for (int j = 0; j < JOINTS; j++) begin
        a = glide(start[j], dst[j], k, c.dur);
        joint_pos[j] = a;
        // right legs are mirrored
        b.angle[j] = (j >= JOINTS / 2) ? angle_t'(ANGLE_MAX - a) : a;
      end
      b.last = (k + 1 == ticks);
      servo_expected.push_back(b);
    end
  endtask

  task automatic send_cmd(motion_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data <= c;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predict_motion(c);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (servo_expected.size() != 0) @(posedge clk);
  endtask

  function automatic motion_cmd_t make_cmd(angle_t t, dur_t d);
    motion_cmd_t c;
    for (int j = 0; j < JOINTS; j++) c.target[j] = t;
    c.dur = d;
    return c;
  endfunction

  function automatic motion_cmd_t random_cmd();
    motion_cmd_t c;
    int unsigned r;
    for (int j = 0; j < JOINTS; j++)
      c.target[j] = ($urandom_range(9) == 0) ? angle_t'($urandom_range(255))
                                              : angle_t'($urandom_range(180));
    r = $urandom_range(99);
    if (r < 75) c.dur = dur_t'($urandom_range(120));
    else if (r < 92) c.dur = dur_t'($urandom_range(400));
    else c.dur = dur_t'($urandom_range(1023));
    return c;
  endfunction

  task automatic test_short_durations();
    send_cmd(make_cmd(8'd90, 10'd0));
    send_cmd(make_cmd(8'd90, 10'd9));
    send_cmd(make_cmd(8'd180, 10'd10));
    send_cmd(make_cmd(8'd0, 10'd19));
  endtask

  task automatic test_extremes();
    motion_cmd_t c;
    send_cmd(make_cmd(8'd180, 10'd640));
    send_cmd(make_cmd(8'd0, 10'd1023));
    send_cmd(make_cmd(8'd255, 10'd650));
    send_cmd(make_cmd(8'hAA, 10'd50));
    send_cmd(make_cmd(8'h55, 10'h155));
    send_cmd(make_cmd(8'h55, 10'd30));
    c.target = {8'd0, 8'd180, 8'd45, 8'd135, 8'd180, 8'd0, 8'd200, 8'd1};
    c.dur = 10'h2AA;
    send_cmd(c);
    c.target = {8'd180, 8'd0, 8'd135, 8'd45, 8'd0, 8'd180, 8'd1, 8'd255};
    c.dur = 10'd97;
    send_cmd(c);
    send_cmd(make_cmd(8'd77, 10'd3));
  endtask

  task automatic test_random(int unsigned n, int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int unsigned i = 0; i < n; i++) begin
      send_cmd(random_cmd());
      if (i == n / 2) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst) servo.ready <= 1'b0;
    else servo.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    servo_beat_t got;
    servo_beat_t want;
    if (!rst && servo.valid && servo.ready) begin
      got = servo.data;
      if (servo_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected servo beat %h", got);
      end else begin
        want = servo_expected.pop_front();
        if (got.angle !== want.angle || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("servo mismatch: expected %h last %b, got %h last %b",
                     want.angle, want.last, got.angle, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("servo_motion_interpolator test failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int j = 0; j < JOINTS; j++) joint_pos[j] = '0;
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_durations();
    test_extremes();
    test_random(90, 28, 65);
    test_random(90, 65, 28);
    test_random(90, 0, 0);
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && servo_expected.size() == 0)
      $display("servo_motion_interpolator test passed");
    else
      $display("servo_motion_interpolator test failed");
    $finish;
  end
endmodule
`default_nettype wire
